@@ src/att_pkg.sv @@
// Shared types, constants and helpers for the allocation tracking table.
// Used by the controller, the datapath and the top level; no dependencies.
package att_pkg;

   localparam int ATT_SLOTS   = 16;
   localparam int ATT_ADDR_W  = 32;
   localparam int ATT_SIZE_W  = 32;
   localparam int ATT_TOTAL_W = 48;
   localparam int ATT_ERR_W   = 4;
   localparam int ATT_REQ_W   = ATT_ADDR_W + ATT_SIZE_W;
   localparam int ATT_RSP_W   = 104;

   // Request kinds carried on req_tuser.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Sticky error bit positions.
   localparam int ERR_NULL_ALLOC   = 0;
   localparam int ERR_FULL         = 1;
   localparam int ERR_NULL_FREE    = 2;
   localparam int ERR_UNKNOWN_FREE = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } att_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } att_cmd_type;

   typedef struct packed {
      logic null_addr;
      logic scan_done;
      logic out_free;
   } att_status_type;

   function automatic logic [ATT_TOTAL_W-1:0] sat_add(input logic [ATT_TOTAL_W-1:0] total,
                                                     input logic [ATT_SIZE_W-1:0] amount);
      logic [ATT_TOTAL_W:0] sum;
      sum = {1'b0, total} + {{(ATT_TOTAL_W - ATT_SIZE_W + 1){1'b0}}, amount};
      sat_add = sum[ATT_TOTAL_W] ? {ATT_TOTAL_W{1'b1}} : sum[ATT_TOTAL_W-1:0];
   endfunction

endpackage

@@ src/att_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module att_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/att_ctrl.sv @@
// Controller state machine for the allocation tracking table.
// Depends on att_pkg; drives commands to att_dp and reads its status.
module att_ctrl
   import att_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  att_status_type status,
   output att_cmd_type    cmd
);

   att_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // A null address never needs the table.
            if (status.null_addr || status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/att_dp.sv @@
// Datapath of the allocation tracking table: request registers, slot scan,
// slot RAM, occupancy bits, totals, sticky errors and the result register.
// Depends on att_pkg and att_ram.
module att_dp
   import att_pkg::*;
#(
   parameter int SLOTS = ATT_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  att_cmd_type           cmd,
   output att_status_type        status,
   input  logic [0:0]            req_tuser,
   input  logic [ATT_REQ_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ATT_RSP_W-1:0]  rsp_tdata
);

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW = $clog2(SLOTS + 1);
   localparam int SLOT_W = ATT_ADDR_W + ATT_SIZE_W;

   // Request registers.
   logic                  req_type_ff;
   logic [ATT_ADDR_W-1:0] req_addr_ff;
   logic [ATT_SIZE_W-1:0] req_size_ff;

   // Scan pipeline: read issue, then compare in the following cycle.
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDXW-1:0]       cmp_idx_ff;
   logic                  found_ff, found_in;
   logic [IDXW-1:0]       found_idx_ff;
   logic [ATT_SIZE_W-1:0] found_size_ff;

   logic [SLOTS-1:0]       occ_ff, occ_in;
   logic [ATT_ERR_W-1:0]   err_ff, err_in;
   logic [ATT_TOTAL_W-1:0] alloc_sum_ff, alloc_sum_in;
   logic [ATT_TOTAL_W-1:0] free_sum_ff, free_sum_in;
   logic                   accepted_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic              rd_en;
   logic [SLOT_W-1:0] rd_data;
   logic              wr_en;
   logic              hit;
   logic              scan_end;
   logic              commit_ok;
   logic              leaked;
   logic              clean;

   att_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(SLOTS),
      .AW   (IDXW)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(found_idx_ff),
      .wr_data({req_size_ff, req_addr_ff}),
      .rd_en  (rd_en),
      .rd_addr(cnt_ff[IDXW-1:0]),
      .rd_data(rd_data)
   );

   assign scan_end = (cnt_ff == CNTW'(SLOTS));
   assign rd_en    = cmd.scan && !scan_end;

   // A free slot is simply one that is not occupied; stored data is only
   // trusted for occupied slots.
   always_comb begin
      if (req_type_ff == REQ_ALLOC) begin
         hit = cmp_valid_ff && !occ_ff[cmp_idx_ff];
      end else begin
         hit = cmp_valid_ff && occ_ff[cmp_idx_ff] &&
               (rd_data[ATT_ADDR_W-1:0] == req_addr_ff);
      end
   end

   assign status.null_addr = (req_addr_ff == '0);
   assign status.scan_done = found_ff || (scan_end && !cmp_valid_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign commit_ok = cmd.commit && !status.null_addr && found_ff;
   assign wr_en     = commit_ok && (req_type_ff == REQ_ALLOC);

   always_comb begin
      cnt_in       = cnt_ff;
      cmp_valid_in = cmp_valid_ff;
      found_in     = found_ff;
      if (cmd.load) begin
         cnt_in       = '0;
         cmp_valid_in = 1'b0;
         found_in     = 1'b0;
      end else if (cmd.scan) begin
         cmp_valid_in = rd_en;
         if (rd_en) begin
            cnt_in = cnt_ff + CNTW'(1);
         end
         if (hit) begin
            found_in = 1'b1;
         end
      end
   end

   always_comb begin
      occ_in       = occ_ff;
      err_in       = err_ff;
      alloc_sum_in = alloc_sum_ff;
      free_sum_in  = free_sum_ff;
      if (cmd.commit) begin
         if (req_type_ff == REQ_ALLOC) begin
            if (status.null_addr) begin
               err_in[ERR_NULL_ALLOC] = 1'b1;
            end else if (found_ff) begin
               occ_in[found_idx_ff] = 1'b1;
               alloc_sum_in         = sat_add(alloc_sum_ff, req_size_ff);
            end else begin
               err_in[ERR_FULL] = 1'b1;
            end
         end else begin
            if (status.null_addr) begin
               err_in[ERR_NULL_FREE] = 1'b1;
            end else if (found_ff) begin
               occ_in[found_idx_ff] = 1'b0;
               free_sum_in          = sat_add(free_sum_ff, found_size_ff);
            end else begin
               err_in[ERR_UNKNOWN_FREE] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         occ_ff       <= '0;
         err_ff       <= '0;
         alloc_sum_ff <= '0;
         free_sum_ff  <= '0;
         accepted_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         occ_ff       <= occ_in;
         err_ff       <= err_in;
         alloc_sum_ff <= alloc_sum_in;
         free_sum_ff  <= free_sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            accepted_ff <= commit_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_tuser[0];
         req_addr_ff <= req_tdata[ATT_ADDR_W-1:0];
         req_size_ff <= req_tdata[ATT_REQ_W-1:ATT_ADDR_W];
      end
      cmp_idx_ff <= cnt_ff[IDXW-1:0];
      if (cmd.scan && hit && !found_ff) begin
         found_idx_ff  <= cmp_idx_ff;
         found_size_ff <= rd_data[SLOT_W-1:ATT_ADDR_W];
      end
   end

   // The totals and flags only change on a commit, which happens only once
   // the previous result has left, so the state registers serve as the
   // result register.
   assign leaked = (alloc_sum_ff != free_sum_ff);
   assign clean  = (err_ff == '0) && !leaked;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, clean, leaked, free_sum_ff, alloc_sum_ff, err_ff, accepted_ff};

endmodule

@@ src/allocation_tracking_table_top.sv @@
// A request with a nonzero address is resolved by the slot scan, which reads one
// RAM entry per cycle; a null-address request skips the scan. A new request is
// taken only once the previous one has been committed. The next request is taken
// while a result waits on rsp_tready.
// Reset (synchronous, active high) frees all slots and clears totals and errors.
// Top level of the allocation tracking table; depends on att_pkg, att_ctrl, att_dp.
module allocation_tracking_table_top
   import att_pkg::*;
#(
   parameter int SLOTS = ATT_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [0:0]           req_tuser,  // [0] req_type
   input  logic [ATT_REQ_W-1:0] req_tdata,  // [31:0] address, [63:32] block_size
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [0] accepted, [4:1] error_flags, [52:5] allocated_total,
   // [100:53] freed_total, [101] leaked, [102] clean, [103] zero
   output logic [ATT_RSP_W-1:0] rsp_tdata
);

   att_cmd_type    cmd;
   att_status_type status;

   att_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   att_dp #(
      .SLOTS(SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ src/att_checker.sv @@
// Port-level checks for the allocation tracking table, bound to the top level.
// Depends on att_pkg.
module att_checker
   import att_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [0:0]           req_tuser,
   input logic [ATT_REQ_W-1:0] req_tdata,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [ATT_RSP_W-1:0] rsp_tdata
);

   logic [ATT_ERR_W-1:0] last_err_ff;

   // Error flags seen on the last delivered beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_err_ff <= rsp_tdata[4:1];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is being worked on");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[4:1] & last_err_ff) == last_err_ff))
      else $error("sticky error flag cleared");

   a_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[102] ==
                      ((rsp_tdata[4:1] == 4'd0) && (rsp_tdata[52:5] == rsp_tdata[100:53]))))
      else $error("clean flag disagrees with errors and totals");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule

bind allocation_tracking_table_top att_checker u_att_checker (.*);

@@ bench/tb_allocation_tracking_table_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for allocation_tracking_table_top: drives allocate and free beats,
// predicts each response in a ledger class and compares it field by field.
// Depends on att_pkg and the RTL of the allocation tracking table.
module tb_allocation_tracking_table_top;
   import att_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 400;
   localparam int RANDOM_ITEMS = 1925;
   localparam int IDLE_PERCENT = 13;
   localparam logic [ATT_TOTAL_W-1:0] TOTAL_CAP = '1;

   typedef struct packed {
      logic                   ok;
      logic [ATT_ERR_W-1:0]   errors;
      logic [ATT_TOTAL_W-1:0] alloc_total;
      logic [ATT_TOTAL_W-1:0] freed_total;
      logic                   leaked;
      logic                   clean;
   } ledger_result_type;

   // Mirror of the slot table and the running totals; one response per request.
   class alloc_ledger;
      logic [ATT_ADDR_W-1:0]  slot_addr [ATT_SLOTS];
      logic [ATT_SIZE_W-1:0]  slot_bytes[ATT_SLOTS];
      logic [ATT_ERR_W-1:0]   sticky;
      logic [ATT_TOTAL_W-1:0] alloc_total;
      logic [ATT_TOTAL_W-1:0] freed_total;
      ledger_result_type      awaited[$];
      int                     failures;
      int                     checked;

      function new();
         foreach (slot_addr[i]) begin
            slot_addr[i]  = '0;
            slot_bytes[i] = '0;
         end
         sticky      = '0;
         alloc_total = '0;
         freed_total = '0;
         failures    = 0;
         checked     = 0;
      endfunction

      function logic [ATT_TOTAL_W-1:0] grow(logic [ATT_TOTAL_W-1:0] total,
                                            logic [ATT_SIZE_W-1:0] bytes);
         logic [ATT_TOTAL_W:0] wide;
         wide = {1'b0, total} + (ATT_TOTAL_W + 1)'(bytes);
         return (wide > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : wide[ATT_TOTAL_W-1:0];
      endfunction

      function int first_slot(logic [ATT_ADDR_W-1:0] addr);
         for (int i = 0; i < ATT_SLOTS; i++) begin
            if (slot_addr[i] == addr) return i;
         end
         return ATT_SLOTS;
      endfunction

      function void note_request(logic kind, logic [ATT_ADDR_W-1:0] addr,
                                 logic [ATT_SIZE_W-1:0] bytes);
         ledger_result_type r;
         int k;
         r.ok = 1'b0;
         if (kind == REQ_ALLOC) begin
            if (addr == '0) begin
               sticky[ERR_NULL_ALLOC] = 1'b1;
            end else begin
               // A free slot is one whose address is zero.
               k = first_slot('0);
               if (k == ATT_SLOTS) begin
                  sticky[ERR_FULL] = 1'b1;
               end else begin
                  slot_addr[k]  = addr;
                  slot_bytes[k] = bytes;
                  alloc_total   = grow(alloc_total, bytes);
                  r.ok          = 1'b1;
               end
            end
         end else begin
            if (addr == '0) begin
               sticky[ERR_NULL_FREE] = 1'b1;
            end else begin
               k = first_slot(addr);
               if (k == ATT_SLOTS) begin
                  sticky[ERR_UNKNOWN_FREE] = 1'b1;
               end else begin
                  slot_addr[k] = '0;
                  freed_total  = grow(freed_total, slot_bytes[k]);
                  r.ok         = 1'b1;
               end
            end
         end
         r.errors      = sticky;
         r.alloc_total = alloc_total;
         r.freed_total = freed_total;
         r.leaked      = (alloc_total != freed_total);
         r.clean       = (sticky == '0) && !r.leaked;
         awaited.push_back(r);
      endfunction

      function void field_check(string name, logic [ATT_TOTAL_W-1:0] want,
                                logic [ATT_TOTAL_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(logic [ATT_RSP_W-1:0] data);
         ledger_result_type want;
         if (awaited.size() == 0) begin
            $error("response beat with no request outstanding: 0x%0h", data);
            failures++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         field_check("accepted", want.ok, data[0]);
         field_check("error_flags", want.errors, data[4:1]);
         field_check("allocated_total", want.alloc_total, data[52:5]);
         field_check("freed_total", want.freed_total, data[100:53]);
         field_check("leaked", want.leaked, data[101]);
         field_check("clean", want.clean, data[102]);
      endfunction

      // Address of a random occupied slot, or zero when the table is empty.
      function logic [ATT_ADDR_W-1:0] pick_live();
         logic [ATT_ADDR_W-1:0] live[$];
         foreach (slot_addr[i]) begin
            if (slot_addr[i] != '0) live.push_back(slot_addr[i]);
         end
         if (live.size() == 0) return '0;
         return live[$urandom_range(live.size() - 1)];
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [0:0]           req_tuser  = '0;
   logic [ATT_REQ_W-1:0] req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ATT_RSP_W-1:0] rsp_tdata;

   bit          idle_on     = 1'b1;
   bit          hold_done   = 1'b0;
   int          hold_left   = 0;
   int          beats_taken = 0;
   int          stall_count = 0;
   int          n_alloc     = 0;
   int          n_free      = 0;
   alloc_ledger ledger      = new();

   allocation_tracking_table_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Receiver: random back-pressure, plus one long hold-off once traffic is flowing.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) beats_taken <= beats_taken + 1;
      if (!hold_done && beats_taken >= HOLD_AFTER) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // Valid stays high between back-to-back beats; it only drops during an idle gap.
   task automatic send_request(input logic kind, input logic [ATT_ADDR_W-1:0] addr,
                               input logic [ATT_SIZE_W-1:0] bytes);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {bytes, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.note_request(kind, addr, bytes);
      if (kind == REQ_ALLOC) n_alloc++;
      else n_free++;
   endtask

   function automatic logic [ATT_ADDR_W-1:0] random_addr();
      logic [ATT_ADDR_W-1:0] addr;
      case ($urandom_range(3))
         0: begin
            // A small pool makes duplicate addresses common.
            addr = $urandom_range(8, 1);
         end
         1: begin
            addr = 32'hFFFF_FFFF - $urandom_range(3);
         end
         default: begin
            addr = $urandom();
            if (addr == '0) addr = 32'h1;
         end
      endcase
      return addr;
   endfunction

   function automatic logic [ATT_SIZE_W-1:0] random_size();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return $urandom_range(4096);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_request();
      int                    pick;
      logic [ATT_ADDR_W-1:0] addr;
      logic [ATT_ADDR_W-1:0] live;
      logic [ATT_SIZE_W-1:0] bytes;
      pick  = $urandom_range(99);
      addr  = random_addr();
      bytes = random_size();
      live  = ledger.pick_live();
      if (pick < 44 || (pick < 88 && live == '0)) begin
         send_request(REQ_ALLOC, addr, bytes);
      end else if (pick < 88) begin
         send_request(REQ_FREE, live, bytes);
      end else if (pick < 94) begin
         send_request(REQ_FREE, addr, bytes);
      end else if (pick < 97) begin
         send_request(REQ_ALLOC, '0, bytes);
      end else begin
         send_request(REQ_FREE, '0, bytes);
      end
   endtask

   initial begin : stimulus
      logic [ATT_ADDR_W-1:0] addr;
      int                    extra;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Clean state is only visible before the first error sets a sticky bit.
      send_request(REQ_ALLOC, 32'h0000_0001, 32'h0);
      send_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_FREE, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(REQ_FREE, 32'h0000_0001, 32'hFFFF_FFFF);
      send_request(REQ_ALLOC, '0, 32'hFFFF_FFFF);
      send_request(REQ_FREE, '0, 32'h0);
      send_request(REQ_FREE, 32'hDEAD_BEEF, 32'h0);
      // Fill every slot, the first two with the same address, then overflow the table.
      send_request(REQ_ALLOC, 32'h0000_0100, 32'h0000_0011);
      send_request(REQ_ALLOC, 32'h0000_0100, 32'h0000_0022);
      for (int i = 2; i < ATT_SLOTS; i++) begin
         send_request(REQ_ALLOC, 32'h8000_0000 | i, i * 32'h1000);
      end
      send_request(REQ_ALLOC, 32'h0000_0200, 32'h0000_0005);
      send_request(REQ_FREE, 32'h0000_0100, 32'hFFFF_FFFF);
      send_request(REQ_FREE, 32'h0000_0100, 32'h0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 800) idle_on <= 1'b0;
         if (n == 1100) idle_on <= 1'b1;
         random_request();
      end

      // Empty the table, then cycle a few maximum-size blocks back to back.
      addr = ledger.pick_live();
      while (addr != '0) begin
         send_request(REQ_FREE, addr, $urandom());
         addr = ledger.pick_live();
      end
      idle_on <= 1'b0;
      for (extra = 0; extra < 4; extra++) begin
         addr = $urandom();
         if (addr == '0) addr = 32'h1;
         send_request(REQ_ALLOC, addr, 32'hFFFF_FFFF);
         send_request(REQ_FREE, addr, $urandom());
      end
      req_tvalid <= 1'b0;

      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (ATT_SLOTS + 8) @(posedge clock);

      $display("Checked %0d responses to %0d allocate and %0d free requests,",
               ledger.checked, n_alloc, n_free);
      $display("including null, unknown, duplicate and full-table cases and maximum sizes.");
      if (ledger.failures == 0 && ledger.awaited.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
